[sv/dlef_pkg.sv]
// Shared constants and types for the dual-edge lockout event FIFO.
// No dependencies; every file that uses this package refers to it by scoped names.
package dlef_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // Field widths
  localparam int TIME_W    = 63;
  localparam int LOCKOUT_W = 20;
  localparam int EV_W      = 1 + TIME_W;   // kind bit over timestamp

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = LOCKOUT_W'(1000);

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Event kinds, also the channel index
  localparam logic KIND_CLK = 1'b0;
  localparam logic KIND_RST = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE       = 3'b001,
    ST_SAMPLE_RST = 3'b010,
    ST_POP_DONE   = 3'b100
  } state_t;

endpackage

[sv/dlef_in_if.sv]
// Input channel: sample tick or pop request, valid/ready handshake.
// Depends on dlef_pkg for field widths.
interface dlef_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic                        clk_level;
  logic                        rst_level;
  logic [dlef_pkg::TIME_W-1:0] now_us;

  modport source (output valid, cmd, clk_level, rst_level, now_us, input ready);
  modport sink   (input valid, cmd, clk_level, rst_level, now_us, output ready);
endinterface

[sv/dlef_out_if.sv]
// Result channel: popped event or not-found beat, valid/ready handshake.
// Depends on dlef_pkg for field widths.
interface dlef_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic                        event_kind;
  logic [dlef_pkg::TIME_W-1:0] event_time;

  modport source (output valid, found, event_kind, event_time, input ready);
  modport sink   (input valid, found, event_kind, event_time, output ready);
endinterface

[sv/dlef_cfg_if.sv]
// Configuration write channel carrying the lockout register value.
// Depends on dlef_pkg for the register width.
interface dlef_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dlef_pkg::LOCKOUT_W-1:0] lockout_us;

  modport source (output valid, lockout_us, input ready);
  modport sink   (input valid, lockout_us, output ready);
endinterface

[sv/dual_edge_lockout_event_fifo.sv]
// Rising-edge detector for a clock line and a reset line with a per-channel
// lockout, feeding a ring of (kind, time) events that is popped on request.
// Depends on dlef_pkg, dlef_in_if, dlef_out_if, dlef_cfg_if, dlef_ring_ram.
//
// In a sample beat, the clock channel is checked and may push in the cycle
// the beat is accepted, the reset channel in the next cycle, as the ring
// has a single write port. A pop beat reads the ring, which has a registered
// read; the result then sits in an output register, and a pop waits only if
// the previous result is still not taken. The ring holds RING_DEPTH-1 events;
// an accepted edge that finds it full still restarts its channel's lockout
// but the event is dropped. A pop of an empty ring returns found = 0 with zero
// kind and time. The lockout register may be written at any time the block is
// idle.
module dual_edge_lockout_event_fifo (
  input  logic              clk,
  input  logic              rst_n,
  dlef_in_if.sink           in_ch,
  dlef_out_if.source        out_ch,
  dlef_cfg_if.sink          cfg_ch
);

  localparam int PTR_W  = dlef_pkg::PTR_W;
  localparam int TIME_W = dlef_pkg::TIME_W;

  dlef_pkg::state_t state_r, state_nxt;

  logic [dlef_pkg::LOCKOUT_W-1:0] lockout_r;
  logic [1:0]                     prev_levels_r;
  logic [1:0]                     seen_r;
  logic [TIME_W-1:0]              last_r [2];
  logic [PTR_W-1:0]               wp_r, rp_r;
  logic                           rst_level_r;
  logic [TIME_W-1:0]              now_r;

  logic                           out_valid_r;
  logic                           found_r;
  logic                           kind_r;
  logic [TIME_W-1:0]              time_r;

  logic                           in_accept;
  logic                           pop_rd;
  logic                           chk_active;
  logic                           ch_sel;
  logic                           chk_level;
  logic [TIME_W-1:0]              chk_now;
  logic [TIME_W-1:0]              chk_last;
  logic [TIME_W-1:0]              diff;
  logic                           rise;
  logic                           take;
  logic [PTR_W-1:0]               wp_inc;
  logic [PTR_W-1:0]               rp_inc;
  logic                           full;
  logic                           empty;
  logic                           push;
  logic                           out_load;

  logic                           ram_en;
  logic [PTR_W-1:0]               ram_addr;
  logic [dlef_pkg::EV_W-1:0]      ram_wdata;
  logic [dlef_pkg::EV_W-1:0]      ram_rdata;

  // Config port: always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= dlef_pkg::LOCKOUT_RESET;
    end else if (cfg_ch.valid) begin
      lockout_r <= cfg_ch.lockout_us;
    end
  end

  // Input handshake
  assign in_ch.ready = (state_r == dlef_pkg::ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign pop_rd      = in_accept && (in_ch.cmd == dlef_pkg::CMD_POP);

  // Shared edge check: clock channel on accept, reset channel in the next cycle
  assign ch_sel     = (state_r == dlef_pkg::ST_SAMPLE_RST) ? dlef_pkg::KIND_RST
                                                          : dlef_pkg::KIND_CLK;
  assign chk_active = (in_accept && (in_ch.cmd == dlef_pkg::CMD_SAMPLE)) ||
                      (state_r == dlef_pkg::ST_SAMPLE_RST);
  assign chk_level  = ch_sel ? rst_level_r : in_ch.clk_level;
  assign chk_now    = ch_sel ? now_r : in_ch.now_us;
  assign chk_last   = last_r[ch_sel];
  assign diff       = chk_now - chk_last;
  assign rise       = chk_level && !prev_levels_r[ch_sel];
  assign take       = chk_active && rise &&
                      (!seen_r[ch_sel] ||
                       ((chk_now >= chk_last) &&
                        (diff >= {{(TIME_W - dlef_pkg::LOCKOUT_W){1'b0}}, lockout_r})));

  // Ring pointers, one slot kept free
  assign wp_inc = (wp_r == PTR_W'(dlef_pkg::RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_W'(dlef_pkg::RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign full   = (wp_inc == rp_r);
  assign empty  = (wp_r == rp_r);
  assign push   = take && !full;

  // Ring access: push writes, pop reads; never in the same cycle
  assign ram_en    = push || pop_rd;
  assign ram_addr  = push ? wp_r : rp_r;
  assign ram_wdata = {ch_sel, chk_now};

  dlef_ring_ram #(
    .DEPTH (dlef_pkg::RING_DEPTH),
    .WIDTH (dlef_pkg::EV_W)
  ) u_ring (
    .clk   (clk),
    .en    (ram_en),
    .we    (push),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Result register loads once the previous beat is gone
  assign out_load = (state_r == dlef_pkg::ST_POP_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dlef_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_ch.cmd == dlef_pkg::CMD_POP) ? dlef_pkg::ST_POP_DONE
                                                        : dlef_pkg::ST_SAMPLE_RST;
        end
      end
      dlef_pkg::ST_SAMPLE_RST: state_nxt = dlef_pkg::ST_IDLE;
      dlef_pkg::ST_POP_DONE: begin
        if (out_load) begin
          state_nxt = dlef_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dlef_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dlef_pkg::ST_IDLE;
      prev_levels_r <= '0;
      seen_r        <= '0;
      last_r[0]     <= '0;
      last_r[1]     <= '0;
      wp_r          <= '0;
      rp_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (chk_active) begin
        prev_levels_r[ch_sel] <= chk_level;
      end
      if (take) begin
        seen_r[ch_sel] <= 1'b1;
        last_r[ch_sel] <= chk_now;
      end
      if (push) begin
        wp_r <= wp_inc;
      end
      if (out_load && !empty) begin
        rp_r <= rp_inc;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample payload held for the reset channel
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rst_level_r <= in_ch.rst_level;
      now_r       <= in_ch.now_us;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      found_r <= !empty;
      kind_r  <= empty ? 1'b0 : ram_rdata[TIME_W];
      time_r  <= empty ? '0 : ram_rdata[TIME_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = found_r;
  assign out_ch.event_kind = kind_r;
  assign out_ch.event_time = time_r;

  // Checks
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && pop_rd))
    else $error("ring written and read in the same cycle");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (wp_r != rp_r))
    else $error("ring empty right after a push");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register loaded over an untaken beat");

  a_sample_two_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_ch.cmd == dlef_pkg::CMD_SAMPLE)) |=>
      (state_r == dlef_pkg::ST_SAMPLE_RST))
    else $error("reset channel step skipped after a sample");

endmodule

[sv/dlef_ring_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No package dependency.
module dlef_ring_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register; rdata holds otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
